FILE: src/moving_average_threshold_signal_assert.svh
// Assertion macros shared by the moving average threshold signal RTL.
`ifndef MOVING_AVERAGE_THRESHOLD_SIGNAL_ASSERT_SVH
`define MOVING_AVERAGE_THRESHOLD_SIGNAL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MATS_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MATS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: src/mats_pkg.sv
// Package with widths, codes, reset values and types for the moving average signal block.
package mats_pkg;

    localparam int unsigned MAX_PERIOD_DEFAULT = 256;

    localparam int unsigned PRICE_W  = 32;
    localparam int unsigned PERIOD_W = 9;
    localparam int unsigned THR_W    = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned SIG_W    = 2;
    localparam int unsigned PROD_W   = 50;
    localparam int unsigned CNT_W    = $clog2(PRICE_W);

    localparam logic [PERIOD_W-1:0]     PERIOD_RESET    = 9'd20;
    localparam logic signed [THR_W-1:0] THRESHOLD_RESET = 16'sd0;

    // Percent scale of the Q8.8 threshold: 100 * 256.
    localparam logic signed [15:0] PCT_SCALE = 16'sd25600;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b1;

    localparam logic [SIG_W-1:0] SIG_HOLD = 2'd0;
    localparam logic [SIG_W-1:0] SIG_BUY  = 2'd1;
    localparam logic [SIG_W-1:0] SIG_SELL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_MUL,
        S_CMP
    } t_state;

endpackage

FILE: src/mats_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mats_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/moving_average_threshold_signal.sv
// Top level of the moving average threshold signal block.
// Full window: an accepted price passes through LOAD, DIV, MUL and CMP before the result is registered.
// DIV is a bit-serial divider, one quotient bit per cycle. A new price is taken only back in IDLE.
// Window not yet full: the price goes from LOAD straight to CMP; CMP waits while a result is held.
// Synchronous active-low reset sets period to twenty and threshold to zero, clears sum and fill.
// The price memory is not cleared; the fill count guards every read, so no clearing pass is needed.
module moving_average_threshold_signal #(
    parameter int unsigned MAX_PERIOD = mats_pkg::MAX_PERIOD_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mats_pkg::PRICE_W-1:0]    i_price,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mats_pkg::PRICE_W-1:0]    o_average,
    output logic [mats_pkg::SIG_W-1:0]      o_signal,
    output logic                            o_window_full,
    input  logic                            i_cfg_we,
    input  logic [mats_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mats_pkg::CFG_W-1:0]      i_cfg_data
);

    import mats_pkg::*;

    localparam int unsigned AW = $clog2(MAX_PERIOD);
    localparam int unsigned PW = $clog2(MAX_PERIOD + 1);
    localparam int unsigned SW = PRICE_W + AW;
    localparam int unsigned CW = (PW > PERIOD_W) ? PW : PERIOD_W;

    t_state                     r_state, n_state;
    logic [PERIOD_W-1:0]        r_period, n_period;
    logic signed [THR_W-1:0]    r_threshold, n_threshold;
    logic [SW-1:0]              r_sum, n_sum;
    logic [AW-1:0]              r_wpos, n_wpos;
    logic [PW-1:0]              r_fill, n_fill;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       r_out_valid, n_out_valid;

    logic [PRICE_W-1:0]         r_price, n_price;
    logic [AW-1:0]              r_pos, n_pos;
    logic                       r_was_full, n_was_full;
    logic                       r_full, n_full;
    logic [PRICE_W-1:0]         r_quo, n_quo;
    logic [PW-1:0]              r_rem, n_rem;
    logic signed [PROD_W-1:0]   r_lhs, n_lhs;
    logic signed [PROD_W-1:0]   r_rhs, n_rhs;
    logic signed [PROD_W-1:0]   r_nrhs, n_nrhs;
    logic [PRICE_W-1:0]         r_out_avg, n_out_avg;
    logic [SIG_W-1:0]           r_out_sig, n_out_sig;
    logic                       r_out_full, n_out_full;

    logic [CW-1:0]              period_ext;
    logic [PW-1:0]              eff_p;
    logic [AW-1:0]              cur_pos;
    logic [PW-1:0]              pos_inc;
    logic [AW-1:0]              next_wpos;
    logic                       was_full;
    logic [PW-1:0]              fill_new;
    logic [SW-1:0]              sum_sub;
    logic [PW:0]                trial;
    logic [PW:0]                trial_diff;
    logic                       trial_ge;
    logic signed [PRICE_W+1:0]  diff_s;
    logic signed [PRICE_W:0]    quo_s;
    logic signed [THR_W:0]      thr_neg;
    logic signed [PROD_W-1:0]   lhs_val;
    logic signed [PROD_W-1:0]   rhs_val;
    logic signed [PROD_W-1:0]   nrhs_val;

    logic                       ram_we;
    logic [PRICE_W-1:0]         ram_rdata;

    mats_ram #(
        .WIDTH (PRICE_W),
        .DEPTH (MAX_PERIOD)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_price),
        .i_raddr (cur_pos),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        period_ext = CW'(r_period);
        if (r_period == '0) begin
            eff_p = PW'(1);
        end else if (period_ext > CW'(MAX_PERIOD)) begin
            eff_p = PW'(MAX_PERIOD);
        end else begin
            eff_p = period_ext[PW-1:0];
        end

        cur_pos   = (PW'(r_wpos) >= eff_p) ? '0 : r_wpos;
        pos_inc   = PW'(cur_pos) + PW'(1);
        next_wpos = (pos_inc >= eff_p) ? '0 : pos_inc[AW-1:0];
        was_full  = (r_fill >= eff_p);
        fill_new  = was_full ? r_fill : r_fill + PW'(1);

        sum_sub    = r_was_full ? r_sum - SW'(ram_rdata) : r_sum;
        trial      = {r_rem, r_quo[PRICE_W-1]};
        trial_diff = trial - {1'b0, eff_p};
        trial_ge   = (trial >= {1'b0, eff_p});

        diff_s   = signed'({2'b00, r_price}) - signed'({2'b00, r_quo});
        quo_s    = signed'({1'b0, r_quo});
        thr_neg  = signed'(17'd0 - {r_threshold[THR_W-1], r_threshold});
        lhs_val  = PROD_W'(diff_s) * PROD_W'(PCT_SCALE);
        rhs_val  = PROD_W'(r_threshold) * PROD_W'(quo_s);
        nrhs_val = PROD_W'(thr_neg) * PROD_W'(quo_s);
    end

    always_comb begin
        n_state     = r_state;
        n_period    = r_period;
        n_threshold = r_threshold;
        n_sum       = r_sum;
        n_wpos      = r_wpos;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_price     = r_price;
        n_pos       = r_pos;
        n_was_full  = r_was_full;
        n_full      = r_full;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_lhs       = r_lhs;
        n_rhs       = r_rhs;
        n_nrhs      = r_nrhs;
        n_out_avg   = r_out_avg;
        n_out_sig   = r_out_sig;
        n_out_full  = r_out_full;
        ram_we      = 1'b0;
        o_ready     = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_price    = i_price;
                    n_pos      = cur_pos;
                    n_was_full = was_full;
                    n_full     = (fill_new >= eff_p);
                    n_fill     = fill_new;
                    n_sum      = r_sum + SW'(i_price);
                    n_wpos     = next_wpos;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                ram_we  = 1'b1;
                n_sum   = sum_sub;
                n_quo   = sum_sub[PRICE_W-1:0];
                n_rem   = PW'(sum_sub[SW-1:PRICE_W]);
                n_cnt   = '0;
                n_state = r_full ? S_DIV : S_CMP;
            end
            S_DIV: begin
                n_rem = trial_ge ? trial_diff[PW-1:0] : trial[PW-1:0];
                n_quo = {r_quo[PRICE_W-2:0], trial_ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(PRICE_W - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_lhs   = lhs_val;
                n_rhs   = rhs_val;
                n_nrhs  = nrhs_val;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_full  = r_full;
                    n_out_avg   = r_full ? r_quo : '0;
                    if (!r_full || r_quo == '0) begin
                        n_out_sig = SIG_HOLD;
                    end else if (r_lhs > r_rhs) begin
                        n_out_sig = SIG_BUY;
                    end else if (r_lhs < r_nrhs) begin
                        n_out_sig = SIG_SELL;
                    end else begin
                        n_out_sig = SIG_HOLD;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PERIOD: begin
                    n_period = i_cfg_data[PERIOD_W-1:0];
                    n_sum    = '0;
                    n_wpos   = '0;
                    n_fill   = '0;
                end
                REG_THRESHOLD: begin
                    n_threshold = signed'(i_cfg_data[THR_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= PERIOD_RESET;
            r_threshold <= THRESHOLD_RESET;
            r_sum       <= '0;
            r_wpos      <= '0;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_period    <= n_period;
            r_threshold <= n_threshold;
            r_sum       <= n_sum;
            r_wpos      <= n_wpos;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_price    <= n_price;
        r_pos      <= n_pos;
        r_was_full <= n_was_full;
        r_full     <= n_full;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_lhs      <= n_lhs;
        r_rhs      <= n_rhs;
        r_nrhs     <= n_nrhs;
        r_out_avg  <= n_out_avg;
        r_out_sig  <= n_out_sig;
        r_out_full <= n_out_full;
    end

    assign o_valid       = r_out_valid;
    assign o_average     = r_out_avg;
    assign o_signal      = r_out_sig;
    assign o_window_full = r_out_full;

    `include "moving_average_threshold_signal_assert.svh"

    `MATS_ASSERT_IMP(a_fill_bounded, i_clk, i_rst_n, 1'b1, (r_fill <= eff_p) && (PW'(r_wpos) < eff_p), "fill count or write position beyond the period")
    `MATS_ASSERT_IMP(a_rem_bounded, i_clk, i_rst_n, r_state == S_DIV, r_rem < eff_p, "divider remainder not below the period")
    `MATS_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, i_valid && o_ready, r_state == S_LOAD, "accepted transaction did not start a window update")
    `MATS_ASSERT_IMP(a_signal_needs_full, i_clk, i_rst_n, o_valid && !o_window_full, (o_signal == SIG_HOLD) && (o_average == '0), "result before the window filled is not a hold with zero average")

endmodule

FILE: tb/mats_signal_checker.sv
// Checker that predicts and compares the moving average signal results of the block.
module mats_signal_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [mats_pkg::PRICE_W-1:0]      i_price,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [mats_pkg::PRICE_W-1:0]      i_average,
    input  logic [mats_pkg::SIG_W-1:0]        i_signal,
    input  logic                              i_window_full,
    input  logic                              i_cfg_we,
    input  logic [mats_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mats_pkg::CFG_W-1:0]        i_cfg_data,
    output int                                o_error_count,
    output int                                o_outstanding,
    output int                                o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import mats_pkg::*;

    typedef struct {
        logic [PRICE_W-1:0] average;
        logic [SIG_W-1:0]   signal;
        logic               full;
    } t_crossover;

    logic [PRICE_W-1:0]      price_hist [MAX_PERIOD_DEFAULT];
    longint unsigned         running_sum;
    int unsigned             wr_pos;
    int unsigned             fill_cnt;
    logic [PERIOD_W-1:0]     period_reg;
    logic signed [THR_W-1:0] thresh_reg;
    t_crossover              expected_quotes [$];

    initial begin
        o_error_count  = 0;
        o_outstanding  = 0;
        o_result_count = 0;
    end

    function automatic int unsigned window_len();
        if (period_reg == 0) begin
            return 1;
        end
        if (period_reg > MAX_PERIOD_DEFAULT) begin
            return MAX_PERIOD_DEFAULT;
        end
        return period_reg;
    endfunction

    function automatic void clear_window();
        running_sum = 0;
        wr_pos      = 0;
        fill_cnt    = 0;
    endfunction

    function automatic void advance_window(input logic [PRICE_W-1:0] price);
        int unsigned len;
        int unsigned pos;
        t_crossover  r;
        longint      diff;
        longint      lim;
        len = window_len();
        pos = wr_pos;
        if (pos >= len) begin
            pos = 0;
        end
        if (fill_cnt >= len) begin
            running_sum -= {32'd0, price_hist[pos]};
        end else begin
            fill_cnt++;
        end
        running_sum += {32'd0, price};
        price_hist[pos] = price;
        pos++;
        if (pos >= len) begin
            pos = 0;
        end
        wr_pos = pos;
        r.full    = (fill_cnt >= len);
        r.average = '0;
        r.signal  = SIG_HOLD;
        if (r.full) begin
            r.average = PRICE_W'(running_sum / len);
            if (r.average != 0) begin
                diff = (longint'({32'd0, price}) - longint'({32'd0, r.average}))
                       * longint'(PCT_SCALE);
                lim  = longint'(thresh_reg) * longint'({32'd0, r.average});
                if (diff > lim) begin
                    r.signal = SIG_BUY;
                end else if (diff < -lim) begin
                    r.signal = SIG_SELL;
                end
            end
        end
        expected_quotes.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        t_crossover exp_q;
        if (!i_rst_n) begin
            period_reg = PERIOD_RESET;
            thresh_reg = THRESHOLD_RESET;
            clear_window();
            expected_quotes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PERIOD: begin
                        period_reg = i_cfg_data[PERIOD_W-1:0];
                        clear_window();
                    end
                    REG_THRESHOLD: begin
                        thresh_reg = i_cfg_data[THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                advance_window(i_price);
            end
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (expected_quotes.size() == 0) begin
                    o_error_count++;
                    $display("%0t: result with nothing expected: average %0h signal %0d full %0b",
                             $time, i_average, i_signal, i_window_full);
                end else begin
                    exp_q = expected_quotes.pop_front();
                    if (i_average !== exp_q.average) begin
                        o_error_count++;
                        $display("%0t: average mismatch: expected %0h actual %0h",
                                 $time, exp_q.average, i_average);
                    end
                    if (i_signal !== exp_q.signal) begin
                        o_error_count++;
                        $display("%0t: signal mismatch: expected %0d actual %0d",
                                 $time, exp_q.signal, i_signal);
                    end
                    if (i_window_full !== exp_q.full) begin
                        o_error_count++;
                        $display("%0t: window_full mismatch: expected %0b actual %0b",
                                 $time, exp_q.full, i_window_full);
                    end
                end
            end
        end
        o_outstanding = expected_quotes.size();
    end

endmodule

FILE: tb/tb_moving_average_threshold_signal.sv
// Testbench top that drives prices and configuration into the moving average signal block.
module tb_moving_average_threshold_signal;
    timeunit 1ns;
    timeprecision 1ps;
    import mats_pkg::*;

    localparam int TARGET_ITEMS   = 1950;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [PRICE_W-1:0]   i_price     = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [PRICE_W-1:0]   o_average;
    logic [SIG_W-1:0]     o_signal;
    logic                 o_window_full;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_PERIOD;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    int err_count;
    int outstanding;
    int result_count;
    int sent_items   = 0;
    int phase_count  = 0;
    int quiet_cycles = 0;
    bit steady       = 1'b0;

    always #5 i_clk = ~i_clk;

    moving_average_threshold_signal uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_price       (i_price),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_average     (o_average),
        .o_signal      (o_signal),
        .o_window_full (o_window_full),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    mats_signal_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_price        (i_price),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_average      (o_average),
        .i_signal       (o_signal),
        .i_window_full  (o_window_full),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_error_count  (err_count),
        .o_outstanding  (outstanding),
        .o_result_count (result_count)
    );

    task automatic send_price(input logic [PRICE_W-1:0] price);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_price <= price;
        do @(posedge i_clk); while (!o_ready);
        sent_items++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_period();
        logic [CFG_W-1:0] v;
        case ($urandom_range(0, 11))
            0:       v = '0;
            1:       v = CFG_W'(1);
            2:       v = CFG_W'(MAX_PERIOD_DEFAULT);
            3:       v = CFG_W'($urandom_range(MAX_PERIOD_DEFAULT + 1, 511));
            4:       v = CFG_W'($urandom_range(17, MAX_PERIOD_DEFAULT - 1));
            default: v = CFG_W'($urandom_range(1, 16));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            v[CFG_W-1:PERIOD_W] = (CFG_W - PERIOD_W)'($urandom);
        end
        return v;
    endfunction

    function automatic int unsigned window_span(input logic [CFG_W-1:0] v);
        logic [PERIOD_W-1:0] p;
        p = v[PERIOD_W-1:0];
        if (p == 0) begin
            return 1;
        end
        if (p > MAX_PERIOD_DEFAULT) begin
            return MAX_PERIOD_DEFAULT;
        end
        return p;
    endfunction

    function automatic logic [CFG_W-1:0] pick_threshold();
        logic [CFG_W-1:0] v;
        case ($urandom_range(0, 11))
            0:       v = '0;
            1:       v = 16'h7FFF;
            2:       v = 16'h8000;
            3:       v = CFG_W'($urandom);
            default: v = CFG_W'($urandom_range(0, 5120) - 2560);
        endcase
        return v;
    endfunction

    function automatic logic [PRICE_W-1:0] pick_base();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 3);
            1:       return 32'hFFFF_FF00 | $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PRICE_W-1:0] next_price(input logic [PRICE_W-1:0] base);
        logic [PRICE_W:0]   sum;
        logic [PRICE_W-1:0] spread;
        logic [PRICE_W-1:0] offset;
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom;
            default: begin
                spread = base >> $urandom_range(3, 12);
                if (spread < 3) begin
                    spread = 3;
                end
                offset = $urandom_range(0, spread);
                if ($urandom_range(0, 1) == 1) begin
                    sum = {1'b0, base} + {1'b0, offset};
                    return sum[PRICE_W] ? '1 : sum[PRICE_W-1:0];
                end
                return (offset > base) ? '0 : base - offset;
            end
        endcase
    endfunction

    initial begin
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_moving_average_threshold_signal: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [CFG_W-1:0]   period_val;
        logic [PRICE_W-1:0] base;
        int unsigned        span;
        int                 count;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: a window of twenty, full-scale sum, then a drop.
        repeat (19) send_price('1);
        send_price('0);
        settle();

        // Period zero acts as one; the most negative threshold makes both tests pass.
        write_reg(REG_PERIOD, '0);
        write_reg(REG_THRESHOLD, 16'h8000);
        end_writes();
        send_price('0);
        send_price('1);
        settle();

        // One percent threshold hit exactly on both sides, then crossed.
        write_reg(REG_THRESHOLD, 16'd256);
        write_reg(REG_PERIOD, 16'd2);
        end_writes();
        send_price(32'd99);
        send_price(32'd101);
        send_price(32'd99);
        send_price(32'd102);
        send_price(32'd98);
        settle();
        span = 2;

        while (sent_items < TARGET_ITEMS) begin
            phase_count++;
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_THRESHOLD, pick_threshold());
            end else begin
                period_val = pick_period();
                span = window_span(period_val);
                if ($urandom_range(0, 1) == 1) begin
                    write_reg(REG_PERIOD, period_val);
                    write_reg(REG_THRESHOLD, pick_threshold());
                end else begin
                    write_reg(REG_THRESHOLD, pick_threshold());
                    write_reg(REG_PERIOD, period_val);
                end
            end
            end_writes();
            base = pick_base();
            count = span + $urandom_range(4, 40);
            repeat (count) send_price(next_price(base));
            settle();
        end

        $display("Sent %0d prices over %0d configuration phases; %0d results checked.",
                 sent_items, phase_count, result_count);
        if (err_count == 0 && outstanding == 0) begin
            $display("tb_moving_average_threshold_signal: clean");
        end else begin
            $display("tb_moving_average_threshold_signal: errors");
        end
        $finish;
    end

endmodule
